### hw/rtl/kcl_pkg.sv
// kcl_pkg: shared types, constants and register indexes for the keypad code lock.
// Used by kcl_decode, kcl_debounce, kcl_entry and keypad_code_lock_top.
package kcl_pkg;

    // field widths
    localparam int SAMPLE_W   = 10;
    localparam int KEY_W      = 3;
    localparam int VALUE_W    = 13;
    localparam int COUNT_W    = 3;
    localparam int PASS_W     = 14;
    localparam int TICK_W     = 11;
    localparam int FAIL_W     = 2;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 14;

    localparam int NUM_KEYS    = 5;
    localparam int CODE_DIGITS = 4;
    localparam int MAX_FAILS   = 3;
    localparam int DEC_BASE    = 10;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // reset values of the configuration registers
    localparam logic [PASS_W-1:0]   RST_PASSWORD  = 14'd1234;
    localparam logic [SAMPLE_W-1:0] RST_DEBOUNCE  = 10'd50;
    localparam logic [SAMPLE_W-1:0] RST_TOLERANCE = 10'd10;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_K1  = 10'd870;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_K2  = 10'd738;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_K3  = 10'd274;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_K4  = 10'd453;
    localparam logic [SAMPLE_W-1:0] RST_LEVEL_K5  = 10'd600;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_PASSWORD  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TOLERANCE = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_K1  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_K2  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_K3  = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_K4  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_LEVEL_K5  = 3'd7;

    localparam logic [KEY_W-1:0] KEY_NONE = 3'd0;

    typedef logic [NUM_KEYS-1:0][SAMPLE_W-1:0] t_level_arr;

    typedef enum logic [1:0] {
        VERDICT_NONE     = 2'd0,
        VERDICT_ACCEPT   = 2'd1,
        VERDICT_REJECT   = 2'd2,
        VERDICT_LOCKOUT  = 2'd3
    } t_verdict;

    // one result item as produced by the entry logic
    typedef struct packed {
        logic [KEY_W-1:0]   press_key;
        logic [VALUE_W-1:0] entered_value;
        logic [COUNT_W-1:0] digits_entered;
        t_verdict           verdict;
    } t_result;

endpackage

### hw/rtl/kcl_decode.sv
// kcl_decode: maps one ladder ADC sample to key 1..5 or no key.
// Depends on kcl_pkg.
module kcl_decode
    import kcl_pkg::*;
(
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [SAMPLE_W-1:0] i_tolerance,
    input  t_level_arr          i_levels,
    output logic [KEY_W-1:0]    o_key
);

    logic [NUM_KEYS-1:0][SAMPLE_W-1:0] diff;
    logic [NUM_KEYS-1:0]               hit;

    // absolute distance to every level, in parallel
    always_comb begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            diff[k] = (i_sample >= i_levels[k]) ? (i_sample - i_levels[k])
                                                : (i_levels[k] - i_sample);
            hit[k]  = (diff[k] < i_tolerance);
        end
    end

    // lowest numbered matching key wins: scan from the top down
    always_comb begin
        o_key = KEY_NONE;
        for (int k = NUM_KEYS - 1; k >= 0; k--) begin
            if (hit[k]) begin
                o_key = KEY_W'(k + 1);
            end
        end
    end

endmodule

### hw/rtl/kcl_debounce.sv
// kcl_debounce: tracks decoded key stability and emits press events.
// Depends on kcl_pkg.
module kcl_debounce
    import kcl_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_advance,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [SAMPLE_W-1:0] i_debounce_ticks,
    output logic [KEY_W-1:0]    o_press
);

    logic [KEY_W-1:0]  r_last_key, n_last_key;
    logic [KEY_W-1:0]  r_stable_key, n_stable_key;
    logic [TICK_W-1:0] r_ticks, n_ticks;

    // tick counter restarts on a code change, otherwise counts and saturates
    always_comb begin
        n_last_key   = r_last_key;
        n_ticks      = r_ticks;
        n_stable_key = r_stable_key;
        o_press      = KEY_NONE;
        if (i_key != r_last_key) begin
            n_last_key = i_key;
            n_ticks    = '0;
        end else if (r_ticks != TICK_MAX) begin
            n_ticks = r_ticks + 1'b1;
        end
        if ((n_ticks > TICK_W'(i_debounce_ticks)) && (i_key != r_stable_key)) begin
            n_stable_key = i_key;
            o_press      = i_key;   // release gives KEY_NONE, no press
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_key   <= KEY_NONE;
            r_stable_key <= KEY_NONE;
            r_ticks      <= '0;
        end else if (i_advance) begin
            r_last_key   <= n_last_key;
            r_stable_key <= n_stable_key;
            r_ticks      <= n_ticks;
        end
    end

endmodule

### hw/rtl/kcl_entry.sv
// kcl_entry: builds the four digit code from presses and gives the verdict.
// Depends on kcl_pkg.
module kcl_entry
    import kcl_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [KEY_W-1:0]  i_press,
    input  logic [PASS_W-1:0] i_password,
    output t_result           o_result
);

    localparam int ACC_W = VALUE_W + 4;

    logic [COUNT_W-1:0] r_digit_count, n_digit_count;
    logic [VALUE_W-1:0] r_code_accum, n_code_accum;
    logic [FAIL_W-1:0]  r_fail_count, n_fail_count;

    logic [ACC_W-1:0]   acc_wide;
    logic [VALUE_W-1:0] shown_value;
    logic [COUNT_W-1:0] shown_count;
    logic [FAIL_W-1:0]  fail_inc;
    logic               got_press;

    assign got_press = (i_press != KEY_NONE);
    assign acc_wide  = ACC_W'(r_code_accum) * ACC_W'(DEC_BASE) + ACC_W'(i_press);
    assign fail_inc  = r_fail_count + 1'b1;

    // append a digit, then judge the code once it is complete
    always_comb begin
        n_digit_count = r_digit_count;
        n_code_accum  = r_code_accum;
        n_fail_count  = r_fail_count;
        o_result.verdict = VERDICT_NONE;
        if (got_press) begin
            n_digit_count = r_digit_count + 1'b1;
            n_code_accum  = acc_wide[VALUE_W-1:0];
        end
        shown_value = n_code_accum;
        shown_count = n_digit_count;
        if (got_press && (n_digit_count >= COUNT_W'(CODE_DIGITS))) begin
            if (PASS_W'(n_code_accum) == i_password) begin
                n_fail_count     = '0;
                o_result.verdict = VERDICT_ACCEPT;
            end else if (32'(fail_inc) < MAX_FAILS) begin
                n_fail_count     = fail_inc;
                o_result.verdict = VERDICT_REJECT;
            end else begin
                n_fail_count     = '0;
                o_result.verdict = VERDICT_LOCKOUT;
            end
            n_digit_count = '0;
            n_code_accum  = '0;
        end
        o_result.press_key      = i_press;
        o_result.entered_value  = shown_value;
        o_result.digits_entered = shown_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= '0;
            r_code_accum  <= '0;
            r_fail_count  <= '0;
        end else if (i_advance) begin
            r_digit_count <= n_digit_count;
            r_code_accum  <= n_code_accum;
            r_fail_count  <= n_fail_count;
        end
    end

    // a completing press empties the entry
    a_complete_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && got_press && (r_digit_count == COUNT_W'(CODE_DIGITS - 1)))
        |=> (r_digit_count == '0) && (r_code_accum == '0))
        else $error("entry not cleared after fourth digit");

    // a verdict only comes with a press that shows a full code
    a_verdict_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.verdict != VERDICT_NONE)
        |-> (got_press && (o_result.digits_entered == COUNT_W'(CODE_DIGITS))))
        else $error("verdict without a complete code");

    // lockout restarts the failure count
    a_lockout_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && (o_result.verdict == VERDICT_LOCKOUT)) |=> (r_fail_count == '0))
        else $error("fail count not cleared on lockout");

    // stored failures stay below the lockout threshold
    a_fail_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_fail_count) < MAX_FAILS)
        else $error("fail count reached lockout threshold");

endmodule

### hw/rtl/keypad_code_lock_top.sv
// keypad_code_lock_top: keypad code lock with input register, result register
// and configuration registers. Depends on kcl_pkg, kcl_decode, kcl_debounce, kcl_entry.

// The lock takes one ADC sample item per clock unless o_in_stall is high, and
// returns one result item per sample. A sample is held in the input register,
// decoded, debounced and folded into the code entry combinationally, and the
// result lands in the output register, where it waits while i_out_stall is
// high. Lock state advances exactly when an item moves from the input
// register to the output register, so the sustained rate is one item per
// cycle whenever the output side takes results. Configuration writes take
// effect at once and belong between items, with the block idle.
module keypad_code_lock_top
    import kcl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // sample channel
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_adc_sample,
    // result channel
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [KEY_W-1:0]      o_press_key,
    output logic [VALUE_W-1:0]    o_entered_value,
    output logic [COUNT_W-1:0]    o_digits_entered,
    output logic [1:0]            o_verdict,
    // configuration
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic [PASS_W-1:0]   r_password;
    logic [SAMPLE_W-1:0] r_debounce;
    logic [SAMPLE_W-1:0] r_tolerance;
    t_level_arr          r_levels;

    logic                r_in_valid;
    logic [SAMPLE_W-1:0] r_sample;
    logic                r_out_valid;
    t_result             r_result;

    logic                out_busy;
    logic                advance;
    logic [KEY_W-1:0]    key;
    logic [KEY_W-1:0]    press;
    t_result             result;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_password  <= RST_PASSWORD;
            r_debounce  <= RST_DEBOUNCE;
            r_tolerance <= RST_TOLERANCE;
            r_levels[0] <= RST_LEVEL_K1;
            r_levels[1] <= RST_LEVEL_K2;
            r_levels[2] <= RST_LEVEL_K3;
            r_levels[3] <= RST_LEVEL_K4;
            r_levels[4] <= RST_LEVEL_K5;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PASSWORD:  r_password  <= i_cfg_wdata[PASS_W-1:0];
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_TOLERANCE: r_tolerance <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_LEVEL_K1:  r_levels[0] <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_LEVEL_K2:  r_levels[1] <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_LEVEL_K3:  r_levels[2] <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_LEVEL_K4:  r_levels[3] <= i_cfg_wdata[SAMPLE_W-1:0];
                CFG_LEVEL_K5:  r_levels[4] <= i_cfg_wdata[SAMPLE_W-1:0];
            endcase
        end
    end

    // handshake: the input register moves on whenever the result slot frees
    assign out_busy   = r_out_valid && i_out_stall;
    assign advance    = r_in_valid && !out_busy;
    assign o_in_stall = r_in_valid && out_busy;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_sample <= i_adc_sample;
        end
    end

    kcl_decode u_decode (
        .i_sample    (r_sample),
        .i_tolerance (r_tolerance),
        .i_levels    (r_levels),
        .o_key       (key)
    );

    kcl_debounce u_debounce (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_advance        (advance),
        .i_key            (key),
        .i_debounce_ticks (r_debounce),
        .o_press          (press)
    );

    kcl_entry u_entry (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (advance),
        .i_press    (press),
        .i_password (r_password),
        .o_result   (result)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!out_busy) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_press_key      = r_result.press_key;
    assign o_entered_value  = r_result.entered_value;
    assign o_digits_entered = r_result.digits_entered;
    assign o_verdict        = r_result.verdict;

endmodule
